@@ src/lcg48_pkg.sv @@
// Shared constants, beat types and state encodings of the 48-bit LCG unit.
// Used by the multiply and divide units and the top level.
package lcg48_pkg;

	localparam int LCG_W = 48;
	localparam int DRAW_W = 31;
	localparam int VALUE_W = 32;
	localparam int DIGIT_W = 12;
	localparam int DIGITS = 3;

	localparam logic [DIGITS*DIGIT_W-1:0] LCG_MULT = 36'h5_DEEC_E66D;
	localparam logic [LCG_W-1:0] LCG_ADD = 48'hB;
	localparam logic [LCG_W-1:0] LCG_MASK = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		KIND_RESEED  = 2'd0,
		KIND_BITS    = 2'd1,
		KIND_BOUNDED = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [47:0] seed_value;
		logic [5:0]  bit_count;
		logic [30:0] bound;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] value;
	} out_beat_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

@@ src/lcg48_stream_if.sv @@
// Valid/ready stream channel that carries one beat of a given payload type.
// The payload types come from lcg48_pkg.
interface lcg48_stream_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);

endinterface

@@ src/lcg48_mul.sv @@
// Iterative seed advance: seed * multiplier + addend mod 2^48, one 12-bit
// multiplier digit per cycle. Depends on lcg48_pkg.
module lcg48_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lcg48_pkg::unit_ctl_t             ctl,
	input  logic [lcg48_pkg::LCG_W-1:0]      seed_in,
	output lcg48_pkg::unit_stat_t            stat,
	output logic [lcg48_pkg::LCG_W-1:0]      seed_out
);

	logic [lcg48_pkg::LCG_W-1:0]   seed_q;
	logic [lcg48_pkg::LCG_W-1:0]   acc_q;
	logic [1:0]                    step_q;
	logic                          busy_q;
	logic                          done_q;
	logic [lcg48_pkg::DIGIT_W-1:0] digit;
	logic [lcg48_pkg::LCG_W-1:0]   prod;
	logic [lcg48_pkg::LCG_W-1:0]   partial;
	logic [lcg48_pkg::LCG_W-1:0]   acc_next;
	logic                          last;

	always_comb begin
		digit = lcg48_pkg::LCG_MULT[lcg48_pkg::DIGIT_W*step_q +: lcg48_pkg::DIGIT_W];
		prod = lcg48_pkg::LCG_W'(seed_q * lcg48_pkg::LCG_W'(digit));
		partial = prod << (lcg48_pkg::DIGIT_W * step_q);
		last = (step_q == 2'(lcg48_pkg::DIGITS - 1));
		acc_next = acc_q + partial + (last ? lcg48_pkg::LCG_ADD : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			seed_q <= seed_in;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign seed_out = acc_q;

endmodule

@@ src/lcg48_div.sv @@
// Restoring divider that yields the remainder of a 31-bit draw by a 31-bit
// bound, one quotient bit per cycle. Depends on lcg48_pkg.
module lcg48_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lcg48_pkg::unit_ctl_t           ctl,
	input  logic [lcg48_pkg::DRAW_W-1:0]   dividend,
	input  logic [lcg48_pkg::DRAW_W-1:0]   divisor,
	output lcg48_pkg::unit_stat_t          stat,
	output logic [lcg48_pkg::DRAW_W-1:0]   remainder
);

	logic [lcg48_pkg::DRAW_W-1:0] rem_q;
	logic [lcg48_pkg::DRAW_W-1:0] dvd_q;
	logic [lcg48_pkg::DRAW_W-1:0] dvs_q;
	logic [4:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [lcg48_pkg::DRAW_W:0]   trial;
	logic [lcg48_pkg::DRAW_W:0]   diff;
	logic                         fits;
	logic                         last;

	always_comb begin
		trial = {rem_q, dvd_q[lcg48_pkg::DRAW_W-1]};
		diff = trial - {1'b0, dvs_q};
		fits = (trial >= {1'b0, dvs_q});
		last = (cnt_q == 5'(lcg48_pkg::DRAW_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[lcg48_pkg::DRAW_W-1:0] : trial[lcg48_pkg::DRAW_W-1:0];
			dvd_q <= {dvd_q[lcg48_pkg::DRAW_W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

@@ src/lcg48_random_bounded_unit.sv @@
// 48-bit linear congruential generator with top-bits and bounded draws.
// Depends on lcg48_pkg, lcg48_stream_if, lcg48_mul and lcg48_div.
//
// One beat is taken at a time. A reseed beat finishes in the cycle it is
// taken and gives no result; an unused kind is dropped the same way. Every
// seed advance runs through the digit-serial multiplier: three digit steps
// and a hand-off. A bits draw or a power-of-two (or zero) bounded draw
// then goes from the hand-off through the value register to the output
// register, and the unit is ready for the next beat in the cycle that its
// result is offered. Any other bound adds the remainder divider (31 steps and
// a hand-off) to each attempt; a draw accepted on its first attempt goes
// through the multiplier, the divider and the output register in that order,
// and a rejected draw repeats the whole attempt. A finished result waits in
// the output register while the next beat is taken; a new result is held back until that one is taken.
module lcg48_random_bounded_unit (
	input  logic             clk,
	input  logic             arst_n,
	lcg48_stream_if.sink     item,
	lcg48_stream_if.source   result
);

	lcg48_pkg::state_t      state_q, state_d;
	lcg48_pkg::unit_ctl_t   mul_ctl, div_ctl;
	lcg48_pkg::unit_stat_t  mul_stat, div_stat;

	logic [lcg48_pkg::LCG_W-1:0]   seed_q;
	logic [lcg48_pkg::LCG_W-1:0]   mul_seed;
	logic [1:0]                    kind_q;
	logic [5:0]                    bit_count_q;
	logic [lcg48_pkg::DRAW_W-1:0]  bound_q;
	logic [lcg48_pkg::DRAW_W-1:0]  draw_q;
	logic [lcg48_pkg::DRAW_W-1:0]  rem;
	logic [lcg48_pkg::VALUE_W-1:0] value_q;
	logic [lcg48_pkg::VALUE_W-1:0] out_q;
	logic                          out_valid_q;

	logic                          accept;
	logic [lcg48_pkg::DRAW_W-1:0]  draw;
	logic [5:0]                    n_bits;
	logic [5:0]                    shamt;
	logic [lcg48_pkg::LCG_W-1:0]   shifted;
	logic [lcg48_pkg::VALUE_W-1:0] bits_val;
	logic [lcg48_pkg::VALUE_W-1:0] bound32;
	logic                          pow2;
	logic [2*lcg48_pkg::DRAW_W-1:0] scaled;
	logic [lcg48_pkg::VALUE_W-1:0] test;
	logic                          reject;
	logic                          out_load;

	lcg48_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mul_ctl),
		.seed_in  (seed_q),
		.stat     (mul_stat),
		.seed_out (mul_seed)
	);

	lcg48_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (draw),
		.divisor   (bound_q),
		.stat      (div_stat),
		.remainder (rem)
	);

	always_comb begin
		accept = item.valid && item.ready;
		draw = mul_seed[lcg48_pkg::LCG_W-1 -: lcg48_pkg::DRAW_W];
		n_bits = (bit_count_q > 6'(lcg48_pkg::VALUE_W)) ? 6'(lcg48_pkg::VALUE_W) : bit_count_q;
		shamt = 6'(lcg48_pkg::LCG_W) - n_bits;
		shifted = mul_seed >> shamt;
		bits_val = (n_bits == '0) ? '0 : shifted[lcg48_pkg::VALUE_W-1:0];
		bound32 = {1'b0, bound_q};
		pow2 = ((bound32 & (~bound32 + 32'd1)) == bound32);
		scaled = {{lcg48_pkg::DRAW_W{1'b0}}, bound_q} * {{lcg48_pkg::DRAW_W{1'b0}}, draw};
		test = {1'b0, draw_q} - {1'b0, rem} + bound32 - 32'd1;
		reject = test[lcg48_pkg::VALUE_W-1];
		out_load = (state_q == lcg48_pkg::ST_OUT) && (!out_valid_q || result.ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lcg48_pkg::ST_IDLE: begin
				if (accept && (item.payload.kind == lcg48_pkg::KIND_BITS ||
						item.payload.kind == lcg48_pkg::KIND_BOUNDED)) begin
					state_d = lcg48_pkg::ST_ADV;
				end
			end
			lcg48_pkg::ST_ADV: begin
				if (mul_stat.done) begin
					if (kind_q == lcg48_pkg::KIND_BOUNDED && !pow2) begin
						state_d = lcg48_pkg::ST_DIV;
					end else begin
						state_d = lcg48_pkg::ST_OUT;
					end
				end
			end
			lcg48_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = reject ? lcg48_pkg::ST_ADV : lcg48_pkg::ST_OUT;
				end
			end
			lcg48_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = lcg48_pkg::ST_IDLE;
				end
			end
			default: state_d = lcg48_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = (state_q == lcg48_pkg::ST_IDLE);
		mul_ctl.start = 1'b0;
		div_ctl.start = 1'b0;
		case (state_q)
			lcg48_pkg::ST_IDLE: begin
				mul_ctl.start = accept && (item.payload.kind == lcg48_pkg::KIND_BITS ||
					item.payload.kind == lcg48_pkg::KIND_BOUNDED);
			end
			lcg48_pkg::ST_ADV: begin
				div_ctl.start = mul_stat.done && kind_q == lcg48_pkg::KIND_BOUNDED && !pow2;
			end
			lcg48_pkg::ST_DIV: begin
				mul_ctl.start = div_stat.done && reject;
			end
			default: begin
				mul_ctl.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcg48_pkg::ST_IDLE;
			seed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && item.payload.kind == lcg48_pkg::KIND_RESEED) begin
				seed_q <= (item.payload.seed_value ^ lcg48_pkg::LCG_W'(lcg48_pkg::LCG_MULT)) &
					lcg48_pkg::LCG_MASK;
			end else if (state_q == lcg48_pkg::ST_ADV && mul_stat.done) begin
				seed_q <= mul_seed;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= item.payload.kind;
			bit_count_q <= item.payload.bit_count;
			bound_q <= item.payload.bound;
		end
		if (state_q == lcg48_pkg::ST_ADV && mul_stat.done) begin
			draw_q <= draw;
			if (kind_q == lcg48_pkg::KIND_BITS) begin
				value_q <= bits_val;
			end else begin
				value_q <= lcg48_pkg::VALUE_W'(scaled[2*lcg48_pkg::DRAW_W-1:lcg48_pkg::DRAW_W]);
			end
		end else if (state_q == lcg48_pkg::ST_DIV && div_stat.done) begin
			value_q <= {1'b0, rem};
		end
		if (out_load) begin
			out_q <= value_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.payload.value = $signed(out_q);

`ifndef SYNTHESIS
	a_mul_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_ctl.start |-> (state_q == lcg48_pkg::ST_IDLE || state_q == lcg48_pkg::ST_DIV))
		else $error("seed advance started outside idle or divide");
	a_mul_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.busy |-> state_q == lcg48_pkg::ST_ADV)
		else $error("multiplier busy while sequencer is not waiting on it");
	a_div_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		(div_stat.busy || div_stat.done) |-> state_q == lcg48_pkg::ST_DIV)
		else $error("divider active while sequencer is not waiting on it");
	a_bounded_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcg48_pkg::ST_OUT && kind_q == lcg48_pkg::KIND_BOUNDED && bound_q != '0)
		|-> value_q < {1'b0, bound_q})
		else $error("bounded draw not below its bound");
`endif

endmodule

@@ sim/lcg48_random_bounded_unit_test.sv @@
// Testbench of lcg48_random_bounded_unit: reseed, top-bits and bounded draws
// are checked beat by beat against a predictor of the 48-bit generator.
// Depends on lcg48_pkg, lcg48_stream_if and the unit itself.
module lcg48_random_bounded_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_BEATS = 1800;
	localparam int TAIL_CYCLES = 100;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PRINT_LIMIT = 40;

	logic clk;
	logic arst_n;

	lcg48_stream_if #(.payload_t(lcg48_pkg::in_beat_t)) item_if ();
	lcg48_stream_if #(.payload_t(lcg48_pkg::out_beat_t)) result_if ();

	lcg48_random_bounded_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(result_if)
	);

	logic [lcg48_pkg::LCG_W-1:0] lcg_state = '0;
	logic signed [lcg48_pkg::VALUE_W-1:0] expected_values[$];
	int mismatches = 0;
	int cycle_count = 0;
	bit quiet = 1'b0;
	int ready_stall = 0;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_values.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] ERROR: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [lcg48_pkg::VALUE_W-1:0] draw_top(input logic [5:0] nbits);
		logic [5:0] n;
		lcg_state = lcg_state * {12'd0, lcg48_pkg::LCG_MULT} + lcg48_pkg::LCG_ADD;
		if (nbits == 6'd0)
			return '0;
		n = (nbits > 6'd32) ? 6'd32 : nbits;
		return lcg48_pkg::VALUE_W'(lcg_state >> (lcg48_pkg::LCG_W - n));
	endfunction

	function automatic logic [lcg48_pkg::VALUE_W-1:0] draw_bounded(
		input logic [lcg48_pkg::DRAW_W-1:0] bnd);
		logic [31:0] b;
		logic [31:0] r;
		logic [31:0] v;
		logic [31:0] t;
		logic [63:0] prod;
		b = {1'b0, bnd};
		if ((b & (32'd0 - b)) == b) begin
			r = draw_top(6'(lcg48_pkg::DRAW_W));
			prod = {32'd0, b} * {32'd0, r};
			return prod[62:31];
		end
		do begin
			r = draw_top(6'(lcg48_pkg::DRAW_W));
			v = r % b;
			t = r - v + (b - 32'd1);
		end while (t[31]);
		return v;
	endfunction

	function automatic void predict_beat(input lcg48_pkg::in_beat_t b);
		case (b.kind)
			lcg48_pkg::KIND_RESEED: begin
				lcg_state = (b.seed_value ^ {12'd0, lcg48_pkg::LCG_MULT}) & lcg48_pkg::LCG_MASK;
			end
			lcg48_pkg::KIND_BITS: begin
				expected_values.push_back(draw_top(b.bit_count));
			end
			lcg48_pkg::KIND_BOUNDED: begin
				expected_values.push_back(draw_bounded(b.bound));
			end
			default: begin
			end
		endcase
	endfunction

	function automatic lcg48_pkg::in_beat_t make_beat(input logic [1:0] k,
		input logic [47:0] s, input logic [5:0] n, input logic [30:0] bnd);
		lcg48_pkg::in_beat_t b;
		b.kind = k;
		b.seed_value = s;
		b.bit_count = n;
		b.bound = bnd;
		return b;
	endfunction

	function automatic logic [47:0] rand_seed();
		return {16'($urandom), 32'($urandom)};
	endfunction

	task automatic send_beat(input lcg48_pkg::in_beat_t b);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.payload <= b;
		do @(posedge clk); while (!item_if.ready);
		predict_beat(b);
	endtask

	task automatic hold_until_drained();
		item_if.valid <= 1'b0;
		do @(posedge clk); while (expected_values.size() != 0);
	endtask

	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (quiet) begin
				result_if.ready <= 1'b1;
			end else if (ready_stall > 0) begin
				result_if.ready <= 1'b0;
				ready_stall--;
			end else begin
				result_if.ready <= 1'b1;
				ready_stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		logic signed [lcg48_pkg::VALUE_W-1:0] want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_values.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat, value %0d",
					result_if.payload.value));
			end else begin
				want = expected_values.pop_front();
				if (result_if.payload.value !== want)
					report_mismatch($sformatf("value got %0d (%08h) want %0d (%08h)",
						result_if.payload.value, result_if.payload.value, want, want));
			end
		end
	end

	task automatic test_reseed_extremes();
		send_beat(make_beat(lcg48_pkg::KIND_RESEED, 48'h0, 6'($urandom), 31'($urandom)));
		send_beat(make_beat(lcg48_pkg::KIND_BITS, rand_seed(), 6'd32, 31'($urandom)));
		send_beat(make_beat(lcg48_pkg::KIND_RESEED, 48'hFFFF_FFFF_FFFF, 6'($urandom),
			31'($urandom)));
		send_beat(make_beat(lcg48_pkg::KIND_BITS, rand_seed(), 6'd32, 31'($urandom)));
		// Seeding with the multiplier itself leaves the generator at zero.
		send_beat(make_beat(lcg48_pkg::KIND_RESEED, {12'd0, lcg48_pkg::LCG_MULT},
			6'($urandom), 31'($urandom)));
		send_beat(make_beat(lcg48_pkg::KIND_NONE, rand_seed(), 6'($urandom), 31'($urandom)));
		send_beat(make_beat(lcg48_pkg::KIND_BITS, rand_seed(), 6'd1, 31'($urandom)));
	endtask

	task automatic test_bit_counts();
		send_beat(make_beat(lcg48_pkg::KIND_BITS, rand_seed(), 6'd0, 31'($urandom)));
		send_beat(make_beat(lcg48_pkg::KIND_BITS, rand_seed(), 6'd1, 31'($urandom)));
		send_beat(make_beat(lcg48_pkg::KIND_BITS, rand_seed(), 6'd31, 31'($urandom)));
		send_beat(make_beat(lcg48_pkg::KIND_BITS, rand_seed(), 6'd32, 31'($urandom)));
		send_beat(make_beat(lcg48_pkg::KIND_BITS, rand_seed(), 6'd33, 31'($urandom)));
		send_beat(make_beat(lcg48_pkg::KIND_BITS, rand_seed(), 6'd63, 31'($urandom)));
	endtask

	task automatic test_bounded_edges();
		send_beat(make_beat(lcg48_pkg::KIND_BOUNDED, rand_seed(), 6'($urandom), 31'd0));
		send_beat(make_beat(lcg48_pkg::KIND_BOUNDED, rand_seed(), 6'($urandom), 31'd1));
		send_beat(make_beat(lcg48_pkg::KIND_BOUNDED, rand_seed(), 6'($urandom), 31'd2));
		send_beat(make_beat(lcg48_pkg::KIND_BOUNDED, rand_seed(), 6'($urandom), 31'd3));
		send_beat(make_beat(lcg48_pkg::KIND_BOUNDED, rand_seed(), 6'($urandom),
			31'h4000_0000));
		send_beat(make_beat(lcg48_pkg::KIND_BOUNDED, rand_seed(), 6'($urandom),
			31'h4000_0001));
		send_beat(make_beat(lcg48_pkg::KIND_BOUNDED, rand_seed(), 6'($urandom),
			31'h7FFF_FFFF));
		send_beat(make_beat(lcg48_pkg::KIND_BOUNDED, rand_seed(), 6'($urandom),
			31'h7FFF_FFFE));
	endtask

	task automatic test_drain_pause();
		send_beat(make_beat(lcg48_pkg::KIND_BOUNDED, rand_seed(), 6'($urandom), 31'd1000003));
		send_beat(make_beat(lcg48_pkg::KIND_BITS, rand_seed(), 6'd17, 31'($urandom)));
		hold_until_drained();
	endtask

	task automatic test_random_mix();
		int sent;
		int r;
		logic [1:0] k;
		logic [5:0] n;
		logic [30:0] bnd;
		logic [47:0] s;
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			quiet = (sent >= 700 && sent < 900);
			if (sent == 400 || sent == 1300)
				hold_until_drained();
			r = $urandom_range(0, 99);
			if (r < 10)
				k = lcg48_pkg::KIND_RESEED;
			else if (r < 45)
				k = lcg48_pkg::KIND_BITS;
			else if (r < 95)
				k = lcg48_pkg::KIND_BOUNDED;
			else
				k = lcg48_pkg::KIND_NONE;
			n = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32));
			case ($urandom_range(0, 4))
				0: bnd = 31'($urandom);
				1: bnd = 31'd1 << $urandom_range(0, 30);
				2: bnd = 31'($urandom_range(0, 1000));
				3: bnd = 31'h7FFF_FFFF - 31'($urandom_range(0, 1000));
				default: bnd = 31'h4000_0000 + 31'($urandom_range(0, 1000));
			endcase
			s = ($urandom_range(0, 9) == 0)
				? ({12'd0, lcg48_pkg::LCG_MULT} ^ 48'($urandom_range(0, 15)))
				: rand_seed();
			send_beat(make_beat(k, s, n, bnd));
			if (k != lcg48_pkg::KIND_NONE)
				sent++;
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		item_if.valid <= 1'b0;
		item_if.payload <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reseed_extremes();
		test_bit_counts();
		test_bounded_edges();
		test_drain_pause();
		test_random_mix();

		item_if.valid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_values.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_values.size()));
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
